/* sv/pfla_pkg.sv */
// ----------------------------------------------------------------------------
// pfla_pkg
// shared widths, operation and status codes, controller/datapath interface
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  // the reserved code is served by a default arm
  typedef enum logic [OP_W-1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_UNFORMATTED = 2'd1,
    STAT_NO_SPACE    = 2'd2,
    STAT_BAD_PAGE    = 2'd3
  } status_e;

  typedef struct packed {
    logic    capture;
    logic    start_format;
    logic    start_grow;
    logic    sweep_step;
    logic    pop_read;
    logic    pop_finish;
    logic    push;
    logic    set_status;
    status_e status_code;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic formatted;
    logic head_zero;
    logic grow_ok;
    logic page_bad;
    logic sweep_last;
  } dp_stat_t;

endpackage

/* sv/page_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// linked free list of page numbers with format, allocate, free and growth
// ----------------------------------------------------------------------------
// One word in, one word out, one word at a time. Free, a rejected operation
// and the reserved code finish after the execute state; an allocate that
// pops also waits on one registered read of the link ram. Format walks the
// link ram one entry a cycle, with the size saturated to 2 .. capacity; an
// allocate on an empty list that doubles the page count first walks the new
// half, one page a cycle, and then pops. The next word is taken the cycle
// after a result is loaded. The single write port of the link ram makes the
// sweeps write one link at a time.
// The link ram is not cleared after reset: format writes every link that can
// later be read. A new word is taken while the last result still waits, but
// the next result is held back until that one has been taken.
module page_free_list_allocator_top #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         initial_pages_we_i,
  input  logic [pfla_pkg::COUNT_W-1:0] initial_pages_i,
  // request word
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pfla_pkg::OP_W-1:0]    operation_i,
  input  logic [pfla_pkg::PAGE_W-1:0]  page_number_i,
  // result word
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pfla_pkg::PAGE_W-1:0]  allocated_page_o,
  output logic [pfla_pkg::STAT_W-1:0]  status_o,
  output logic                         grew_o,
  output logic [pfla_pkg::COUNT_W-1:0] page_count_o
);
  import pfla_pkg::*;

  // page numbers are 12 bits wide, so capacity tops out at 4096
  localparam int PageCap = (MAX_PAGES < (1 << PAGE_W)) ? MAX_PAGES : (1 << PAGE_W);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: handshakes and operation flow
  pfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // head, count, link ram and the result word
  pfla_dp #(
    .PAGE_CAP (PageCap)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .operation_i        (operation_i),
    .page_number_i      (page_number_i),
    .initial_pages_we_i (initial_pages_we_i),
    .initial_pages_i    (initial_pages_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .allocated_page_o   (allocated_page_o),
    .status_o           (status_o),
    .grew_o             (grew_o),
    .page_count_o       (page_count_o)
  );

endmodule

/* sv/pfla_ram.sv */
// ----------------------------------------------------------------------------
// pfla_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pfla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pfla_ctrl.sv */
// ----------------------------------------------------------------------------
// pfla_ctrl
// sequencer for format, allocate, free and link sweeps; owns the handshakes
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pfla_pkg::dp_stat_t  stat_i,
  output pfla_pkg::ctrl_cmd_t cmd_o
);
  import pfla_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_POP   = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  ctrl_cmd_t cmd;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.status_code = STAT_OK;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        state_d        = S_DONE;
        unique case (stat_i.op)
          OP_FORMAT: begin
            cmd.start_format = 1'b1;
            state_d          = S_SWEEP;
          end
          OP_ALLOC: begin
            if (!stat_i.formatted) begin
              cmd.status_code = STAT_UNFORMATTED;
            end else if (stat_i.head_zero) begin
              if (stat_i.grow_ok) begin
                cmd.start_grow = 1'b1;
                state_d        = S_SWEEP;
              end else begin
                cmd.status_code = STAT_NO_SPACE;
              end
            end else begin
              cmd.pop_read = 1'b1;
              state_d      = S_POP;
            end
          end
          OP_FREE: begin
            if (!stat_i.formatted) begin
              cmd.status_code = STAT_UNFORMATTED;
            end else if (stat_i.page_bad) begin
              cmd.status_code = STAT_BAD_PAGE;
            end else begin
              cmd.push = 1'b1;
            end
          end
          default: begin
            cmd.status_code = STAT_OK;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = (stat_i.op == OP_ALLOC) ? S_EXEC : S_DONE;
        end
      end
      S_POP: begin
        cmd.pop_finish = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* sv/pfla_dp.sv */
// ----------------------------------------------------------------------------
// pfla_dp
// head, page count, sweep counter, link ram and result registers
// ----------------------------------------------------------------------------
module pfla_dp #(
  parameter int PAGE_CAP = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [pfla_pkg::OP_W-1:0]       operation_i,
  input  logic [pfla_pkg::PAGE_W-1:0]     page_number_i,
  input  logic                            initial_pages_we_i,
  input  logic [pfla_pkg::COUNT_W-1:0]    initial_pages_i,
  input  pfla_pkg::ctrl_cmd_t             cmd_i,
  output pfla_pkg::dp_stat_t              stat_o,
  output logic [pfla_pkg::PAGE_W-1:0]     allocated_page_o,
  output logic [pfla_pkg::STAT_W-1:0]     status_o,
  output logic                            grew_o,
  output logic [pfla_pkg::COUNT_W-1:0]    page_count_o
);
  import pfla_pkg::*;

  localparam int AW = $clog2(PAGE_CAP);
  localparam logic [COUNT_W-1:0] CapCount  = COUNT_W'(PAGE_CAP);
  localparam logic [COUNT_W:0]   CapDouble = (COUNT_W+1)'(PAGE_CAP);
  localparam logic [COUNT_W-1:0] MinPages  = COUNT_W'(2);

  // control state
  logic [PAGE_W-1:0]  head_q, head_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] init_q, init_d;

  // item and sweep registers
  op_e                op_q;
  logic [PAGE_W-1:0]  page_q;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic [COUNT_W-1:0] end_q, end_d;
  logic [PAGE_W-1:0]  res_page_q, res_page_d;
  status_e            res_status_q, res_status_d;
  logic               res_grew_q, res_grew_d;

  // output word
  logic [PAGE_W-1:0]  out_page_q;
  status_e            out_status_q;
  logic               out_grew_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [COUNT_W-1:0] fmt_pages;
  logic [COUNT_W:0]   doubled;
  logic [COUNT_W-1:0] idx_inc;
  logic               sweep_last;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PAGE_W-1:0]  ram_wdata;
  logic [PAGE_W-1:0]  ram_rdata;

  // format size saturated into the usable range
  always_comb begin
    priority if (init_q < MinPages) begin
      fmt_pages = MinPages;
    end else if (init_q > CapCount) begin
      fmt_pages = CapCount;
    end else begin
      fmt_pages = init_q;
    end
  end

  assign doubled    = {total_q, 1'b0};
  assign idx_inc    = idx_q + COUNT_W'(1);
  assign sweep_last = (idx_inc == end_q);

  always_comb begin
    head_d       = head_q;
    total_d      = total_q;
    init_d       = initial_pages_we_i ? initial_pages_i : init_q;
    idx_d        = idx_q;
    end_d        = end_q;
    res_page_d   = res_page_q;
    res_status_d = res_status_q;
    res_grew_d   = res_grew_q;
    if (cmd_i.capture) begin
      res_page_d = '0;
      res_grew_d = 1'b0;
    end
    if (cmd_i.set_status) begin
      res_status_d = cmd_i.status_code;
    end
    if (cmd_i.start_format) begin
      head_d  = PAGE_W'(1);
      total_d = fmt_pages;
      idx_d   = COUNT_W'(1);
      end_d   = fmt_pages;
    end
    if (cmd_i.start_grow) begin
      head_d     = total_q[PAGE_W-1:0];
      total_d    = doubled[COUNT_W-1:0];
      idx_d      = total_q;
      end_d      = doubled[COUNT_W-1:0];
      res_grew_d = 1'b1;
    end
    if (cmd_i.sweep_step) begin
      idx_d = idx_inc;
    end
    if (cmd_i.pop_finish) begin
      res_page_d = head_q;
      head_d     = ram_rdata;
    end
    if (cmd_i.push) begin
      head_d = page_q;
    end
  end

  // link writes: sweep chains ascending pages, free pushes onto the head
  assign ram_we    = cmd_i.sweep_step | cmd_i.push;
  assign ram_waddr = cmd_i.push ? page_q[AW-1:0] : idx_q[AW-1:0];
  assign ram_wdata = cmd_i.push ? head_q :
                     (sweep_last ? '0 : idx_inc[PAGE_W-1:0]);

  pfla_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (PAGE_CAP)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pop_read),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      total_q <= '0;
      init_q  <= COUNT_W'(2560);
    end else begin
      head_q  <= head_d;
      total_q <= total_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(operation_i);
      page_q <= page_number_i;
    end
    idx_q        <= idx_d;
    end_q        <= end_d;
    res_page_q   <= res_page_d;
    res_status_q <= res_status_d;
    res_grew_q   <= res_grew_d;
    if (cmd_i.load_out) begin
      out_page_q   <= res_page_q;
      out_status_q <= res_status_q;
      out_grew_q   <= res_grew_q;
      out_count_q  <= total_q;
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.formatted  = (total_q != '0);
  assign stat_o.head_zero  = (head_q == '0);
  assign stat_o.grow_ok    = (doubled <= CapDouble);
  assign stat_o.page_bad   = (page_q == '0) || ({1'b0, page_q} >= total_q);
  assign stat_o.sweep_last = sweep_last;

  assign allocated_page_o = out_page_q;
  assign status_o         = out_status_q;
  assign grew_o           = out_grew_q;
  assign page_count_o     = out_count_q;

endmodule

/* sv/pfla_checker.sv */
// ----------------------------------------------------------------------------
// pfla_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
module pfla_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [pfla_pkg::PAGE_W-1:0]  allocated_page_o,
  input logic [pfla_pkg::STAT_W-1:0]  status_o,
  input logic                         grew_o,
  input logic [pfla_pkg::COUNT_W-1:0] page_count_o
);
  import pfla_pkg::*;

  // a failed operation never hands out a page
  a_fail_no_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (allocated_page_o == '0))
    else $error("page returned with failing status");

  // growth only on a successful allocate that popped a real page
  a_grew_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grew_o |->
      (status_o == STAT_OK) && (allocated_page_o != '0) && (page_count_o != '0))
    else $error("growth flagged without a successful allocate");

  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(allocated_page_o) && $stable(status_o) &&
      $stable(grew_o) && $stable(page_count_o))
    else $error("stalled result changed");

endmodule

bind page_free_list_allocator_top pfla_checker u_pfla_checker (.*);
